// File: rtl/fralu_pkg.sv
// ----------------------------------------------------------------------------
// fralu_pkg: shared types and constants for the four-register ALU
// Register file geometry, operation codes, configuration indexes, the
// input and result beat structs and a few small helper functions.
// ----------------------------------------------------------------------------
package fralu_pkg;

  localparam int NUM_REGS    = 4;
  localparam int DATA_WIDTH  = 32;
  localparam int IDX_W       = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int OPER_W      = 32;
  localparam int OP_W        = 4;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_INDEX_W-1:0] CFG_OPCODE_MAP = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_USE_MAP    = 1'b1;

  localparam logic [CFG_DATA_W-1:0] OPCODE_MAP_RESET = 64'hFEDC_BA98_7654_3210;

  localparam logic [OP_W-1:0] OP_ADDR = 4'd0;
  localparam logic [OP_W-1:0] OP_ADDI = 4'd1;
  localparam logic [OP_W-1:0] OP_MULR = 4'd2;
  localparam logic [OP_W-1:0] OP_MULI = 4'd3;
  localparam logic [OP_W-1:0] OP_BANR = 4'd4;
  localparam logic [OP_W-1:0] OP_BANI = 4'd5;
  localparam logic [OP_W-1:0] OP_BORR = 4'd6;
  localparam logic [OP_W-1:0] OP_BORI = 4'd7;
  localparam logic [OP_W-1:0] OP_SETR = 4'd8;
  localparam logic [OP_W-1:0] OP_SETI = 4'd9;
  localparam logic [OP_W-1:0] OP_GTIR = 4'd10;
  localparam logic [OP_W-1:0] OP_GTRI = 4'd11;
  localparam logic [OP_W-1:0] OP_GTRR = 4'd12;
  localparam logic [OP_W-1:0] OP_EQIR = 4'd13;
  localparam logic [OP_W-1:0] OP_EQRI = 4'd14;
  localparam logic [OP_W-1:0] OP_EQRR = 4'd15;

  localparam logic CMD_EXEC = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [IDX_W-1:0]      idx_t;

  typedef struct packed {
    logic                     command;
    logic [OP_W-1:0]          opcode;
    logic signed [OPER_W-1:0] operand_a;
    logic signed [OPER_W-1:0] operand_b;
    logic signed [OPER_W-1:0] operand_c;
  } in_t;

  typedef struct packed {
    logic signed [31:0] reg0;
    logic signed [31:0] reg1;
    logic signed [31:0] reg2;
    logic signed [31:0] reg3;
    logic               fault;
  } out_t;

  // Sign-extend (or truncate) a 32-bit immediate to the register width.
  function automatic word_t imm_ext(logic [OPER_W-1:0] v);
    logic signed [63:0] wide;
    wide = 64'(signed'(v));
    return wide[DATA_WIDTH-1:0];
  endfunction

  function automatic logic idx_ok(logic [OPER_W-1:0] v);
    return v < OPER_W'(NUM_REGS);
  endfunction

  // Report a register as its low 32 bits, zero-filled when narrower.
  function automatic logic [31:0] rep_word(word_t w);
    logic [63:0] wide;
    wide = 64'(w);
    return wide[31:0];
  endfunction

endpackage

// File: rtl/four_register_alu_execute.sv
// ----------------------------------------------------------------------------
// four_register_alu_execute: register file and sixteen-operation ALU
// Pipeline: the input register, then ALU and register write into the result
// register. Throughput: one instruction per cycle unless out_ready stalls;
// the ALU, one 32x32 multiplier and the register write all fit in the single
// stage after the input register.
// Reset clears the register file and pipeline valids, restores the opcode map.
// ----------------------------------------------------------------------------
module four_register_alu_execute (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  fralu_pkg::in_t                       in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output fralu_pkg::out_t                      out_data,
  input  logic                                 cfg_we,
  input  logic [fralu_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [fralu_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic                             s1_valid_r;
  fralu_pkg::in_t                   s1_data_r;
  logic                             out_valid_r;
  fralu_pkg::out_t                  out_data_r;
  fralu_pkg::out_t                  out_data_nxt;
  fralu_pkg::word_t                 rf_r   [fralu_pkg::NUM_REGS];
  fralu_pkg::word_t                 rf_nxt [fralu_pkg::NUM_REGS];
  logic [fralu_pkg::CFG_DATA_W-1:0] opcode_map_r;
  logic                             use_map_r;

  logic                             advance;
  logic [fralu_pkg::OP_W-1:0]       op;
  logic                             need_a;
  logic                             need_b;
  logic                             fault;
  fralu_pkg::idx_t                  a_idx;
  fralu_pkg::idx_t                  b_idx;
  fralu_pkg::idx_t                  c_idx;
  fralu_pkg::word_t                 imm_a;
  fralu_pkg::word_t                 imm_b;
  fralu_pkg::word_t                 src_a;
  fralu_pkg::word_t                 src_b;
  fralu_pkg::word_t                 product;
  fralu_pkg::word_t                 alu_res;
  fralu_pkg::word_t                 wr_data;
  logic [31:0]                      rep [4];

  // Stage 1 moves on whenever the result register is free or being drained.
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Operation decode
  always_comb begin
    op = s1_data_r.opcode;
    if (use_map_r) begin
      op = opcode_map_r[{s1_data_r.opcode, 2'b00} +: fralu_pkg::OP_W];
    end
    need_a = !(op == fralu_pkg::OP_SETI || op == fralu_pkg::OP_GTIR ||
               op == fralu_pkg::OP_EQIR);
    need_b = (op == fralu_pkg::OP_ADDR || op == fralu_pkg::OP_MULR ||
              op == fralu_pkg::OP_BANR || op == fralu_pkg::OP_BORR ||
              op == fralu_pkg::OP_GTIR || op == fralu_pkg::OP_GTRR ||
              op == fralu_pkg::OP_EQIR || op == fralu_pkg::OP_EQRR);
  end

  assign a_idx = s1_data_r.operand_a[fralu_pkg::IDX_W-1:0];
  assign b_idx = s1_data_r.operand_b[fralu_pkg::IDX_W-1:0];
  assign c_idx = s1_data_r.operand_c[fralu_pkg::IDX_W-1:0];
  assign imm_a = fralu_pkg::imm_ext(s1_data_r.operand_a);
  assign imm_b = fralu_pkg::imm_ext(s1_data_r.operand_b);

  assign src_a   = need_a ? rf_r[a_idx] : imm_a;
  assign src_b   = need_b ? rf_r[b_idx] : imm_b;
  assign product = src_a * src_b;

  always_comb begin
    fault = !fralu_pkg::idx_ok(s1_data_r.operand_c);
    if (s1_data_r.command == fralu_pkg::CMD_EXEC) begin
      if ((need_a && !fralu_pkg::idx_ok(s1_data_r.operand_a)) ||
          (need_b && !fralu_pkg::idx_ok(s1_data_r.operand_b))) begin
        fault = 1'b1;
      end
    end
  end

  always_comb begin
    alu_res = '0;
    unique case (op)
      fralu_pkg::OP_ADDR, fralu_pkg::OP_ADDI: alu_res = src_a + src_b;
      fralu_pkg::OP_MULR, fralu_pkg::OP_MULI: alu_res = product;
      fralu_pkg::OP_BANR, fralu_pkg::OP_BANI: alu_res = src_a & src_b;
      fralu_pkg::OP_BORR, fralu_pkg::OP_BORI: alu_res = src_a | src_b;
      fralu_pkg::OP_SETR, fralu_pkg::OP_SETI: alu_res = src_a;
      fralu_pkg::OP_GTIR, fralu_pkg::OP_GTRI, fralu_pkg::OP_GTRR: begin
        alu_res = fralu_pkg::word_t'($signed(src_a) > $signed(src_b));
      end
      fralu_pkg::OP_EQIR, fralu_pkg::OP_EQRI, fralu_pkg::OP_EQRR: begin
        alu_res = fralu_pkg::word_t'(src_a == src_b);
      end
    endcase
  end

  assign wr_data = (s1_data_r.command == fralu_pkg::CMD_LOAD) ? imm_a : alu_res;

  always_comb begin
    for (int i = 0; i < fralu_pkg::NUM_REGS; i++) begin
      rf_nxt[i] = rf_r[i];
      if (!fault && c_idx == fralu_pkg::IDX_W'(i)) begin
        rf_nxt[i] = wr_data;
      end
    end
    for (int k = 0; k < 4; k++) begin
      rep[k] = (k < fralu_pkg::NUM_REGS) ?
               fralu_pkg::rep_word(rf_nxt[k % fralu_pkg::NUM_REGS]) : 32'd0;
    end
    out_data_nxt.reg0  = rep[0];
    out_data_nxt.reg1  = rep[1];
    out_data_nxt.reg2  = rep[2];
    out_data_nxt.reg3  = rep[3];
    out_data_nxt.fault = fault;
  end

  // Control state, register file and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      opcode_map_r <= fralu_pkg::OPCODE_MAP_RESET;
      use_map_r    <= 1'b1;
      for (int i = 0; i < fralu_pkg::NUM_REGS; i++) begin
        rf_r[i] <= '0;
      end
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        for (int i = 0; i < fralu_pkg::NUM_REGS; i++) begin
          rf_r[i] <= rf_nxt[i];
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          fralu_pkg::CFG_OPCODE_MAP: opcode_map_r <= cfg_wdata;
          fralu_pkg::CFG_USE_MAP:    use_map_r    <= cfg_wdata[0];
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// File: rtl/fralu_chk.sv
// ----------------------------------------------------------------------------
// fralu_chk: port-level checks for the four-register ALU
// Watches the input and result handshakes over time; bound to the top level.
// ----------------------------------------------------------------------------
module fralu_chk (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input fralu_pkg::out_t out_data
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // With the result side empty the input side never blocks.
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty result register");

  // A fresh result beat follows an accepted input beat via the input register.
  a_rise_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result beat without a matching input beat");

  // Reset drops the result channel.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind four_register_alu_execute fralu_chk u_fralu_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: sim/four_register_alu_execute_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// four_register_alu_execute_test: self-checking bench for the register ALU
// Drives instruction and load beats through the valid/ready input channel,
// predicts the register file after every beat and compares each result beat
// field by field. A short directed table covers extremes and faults, then
// random phases sweep opcode map settings and sender/receiver idling.
// ----------------------------------------------------------------------------
module four_register_alu_execute_test;

  localparam int LATENCY     = 2;
  localparam int PHASES      = 8;
  localparam int PHASE_BEATS = 240;

  typedef struct {
    fralu_pkg::in_t  beat;
    bit              fixed;
    fralu_pkg::out_t result;
  } directed_t;

  logic                              clk       = 1'b0;
  logic                              rst_n     = 1'b0;
  logic                              in_valid  = 1'b0;
  logic                              in_ready;
  fralu_pkg::in_t                    in_data   = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  fralu_pkg::out_t                   out_data;
  logic                              cfg_we    = 1'b0;
  logic [fralu_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [fralu_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Typed-in expectation riding along with the current input beat
  bit              beat_fixed  = 1'b0;
  fralu_pkg::out_t beat_result = '0;

  fralu_pkg::word_t                 arch_regs [fralu_pkg::NUM_REGS];
  logic [fralu_pkg::CFG_DATA_W-1:0] arch_map;
  logic                             arch_use_map;

  fralu_pkg::out_t pending_results [$];
  fralu_pkg::out_t predicted;
  fralu_pkg::out_t oldest;
  int   beats_sent         = 0;
  int   results_checked    = 0;
  int   mismatch_count     = 0;
  int   sender_gap_pct     = 0;
  int   receiver_stall_pct = 0;

  four_register_alu_execute dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [fralu_pkg::OP_W-1:0] decode_op(
      logic [fralu_pkg::OP_W-1:0] opcode);
    return arch_use_map ? arch_map[{opcode, 2'b00} +: fralu_pkg::OP_W] : opcode;
  endfunction

  function automatic bit reads_reg_a(logic [fralu_pkg::OP_W-1:0] op);
    return !(op == fralu_pkg::OP_SETI || op == fralu_pkg::OP_GTIR ||
             op == fralu_pkg::OP_EQIR);
  endfunction

  function automatic bit reads_reg_b(logic [fralu_pkg::OP_W-1:0] op);
    return op == fralu_pkg::OP_ADDR || op == fralu_pkg::OP_MULR ||
           op == fralu_pkg::OP_BANR || op == fralu_pkg::OP_BORR ||
           op == fralu_pkg::OP_GTIR || op == fralu_pkg::OP_GTRR ||
           op == fralu_pkg::OP_EQIR || op == fralu_pkg::OP_EQRR;
  endfunction

  function automatic bit reg_index_ok(logic signed [fralu_pkg::OPER_W-1:0] v);
    return v >= 0 && v < fralu_pkg::NUM_REGS;
  endfunction

  // Apply one beat to the register file copy and return the result beat.
  function automatic fralu_pkg::out_t alu_step(fralu_pkg::in_t beat);
    logic [fralu_pkg::OP_W-1:0] op;
    fralu_pkg::word_t           ra, rb, ia, ib, res;
    logic                       fault;
    fralu_pkg::out_t            r;
    fault = 1'b0;
    res   = '0;
    ia    = beat.operand_a;
    ib    = beat.operand_b;
    ra    = arch_regs[beat.operand_a[fralu_pkg::IDX_W-1:0]];
    rb    = arch_regs[beat.operand_b[fralu_pkg::IDX_W-1:0]];
    op    = decode_op(beat.opcode);
    if (!reg_index_ok(beat.operand_c)) begin
      fault = 1'b1;
    end else if (beat.command == fralu_pkg::CMD_LOAD) begin
      arch_regs[beat.operand_c[fralu_pkg::IDX_W-1:0]] = ia;
    end else if ((reads_reg_a(op) && !reg_index_ok(beat.operand_a)) ||
                 (reads_reg_b(op) && !reg_index_ok(beat.operand_b))) begin
      fault = 1'b1;
    end else begin
      case (op)
        fralu_pkg::OP_ADDR: res = ra + rb;
        fralu_pkg::OP_ADDI: res = ra + ib;
        fralu_pkg::OP_MULR: res = ra * rb;
        fralu_pkg::OP_MULI: res = ra * ib;
        fralu_pkg::OP_BANR: res = ra & rb;
        fralu_pkg::OP_BANI: res = ra & ib;
        fralu_pkg::OP_BORR: res = ra | rb;
        fralu_pkg::OP_BORI: res = ra | ib;
        fralu_pkg::OP_SETR: res = ra;
        fralu_pkg::OP_SETI: res = ia;
        fralu_pkg::OP_GTIR: res = ($signed(ia) > $signed(rb)) ? 32'd1 : 32'd0;
        fralu_pkg::OP_GTRI: res = ($signed(ra) > $signed(ib)) ? 32'd1 : 32'd0;
        fralu_pkg::OP_GTRR: res = ($signed(ra) > $signed(rb)) ? 32'd1 : 32'd0;
        fralu_pkg::OP_EQIR: res = (ia == rb) ? 32'd1 : 32'd0;
        fralu_pkg::OP_EQRI: res = (ra == ib) ? 32'd1 : 32'd0;
        fralu_pkg::OP_EQRR: res = (ra == rb) ? 32'd1 : 32'd0;
      endcase
      arch_regs[beat.operand_c[fralu_pkg::IDX_W-1:0]] = res;
    end
    r.reg0  = arch_regs[0];
    r.reg1  = arch_regs[1];
    r.reg2  = arch_regs[2];
    r.reg3  = arch_regs[3];
    r.fault = fault;
    return r;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endfunction

  function automatic directed_t directed_row(logic cmd, logic [fralu_pkg::OP_W-1:0] op,
      logic [31:0] a, logic [31:0] b, logic [31:0] c, bit fixed = 1'b0,
      logic [31:0] e0 = '0, logic [31:0] e1 = '0, logic [31:0] e2 = '0,
      logic [31:0] e3 = '0, logic ef = 1'b0);
    directed_t row;
    row.beat   = '{command: cmd, opcode: op, operand_a: a, operand_b: b, operand_c: c};
    row.fixed  = fixed;
    row.result = '{reg0: e0, reg1: e1, reg2: e2, reg3: e3, fault: ef};
    return row;
  endfunction

  // Mostly valid register numbers, now and then an out-of-range one
  function automatic logic [31:0] pick_index();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 94) return $urandom_range(0, fralu_pkg::NUM_REGS - 1);
    case (roll)
      94:      return fralu_pkg::NUM_REGS;
      95:      return 32'hFFFF_FFFF;
      96:      return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_immediate();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h7FFF_FFFF;
      4:       return 32'h8000_0000;
      5:       return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  // Shape operands after the operation the beat will decode to.
  function automatic fralu_pkg::in_t random_instruction();
    fralu_pkg::in_t             b;
    logic [fralu_pkg::OP_W-1:0] op;
    bit                         exec;
    b.command = ($urandom_range(0, 99) < 20) ? fralu_pkg::CMD_LOAD : fralu_pkg::CMD_EXEC;
    b.opcode  = fralu_pkg::OP_W'($urandom_range(0, 15));
    if ($urandom_range(0, 99) < 8) begin
      b.operand_a = $urandom;
      b.operand_b = $urandom;
      b.operand_c = $urandom;
      return b;
    end
    op          = decode_op(b.opcode);
    exec        = (b.command == fralu_pkg::CMD_EXEC);
    b.operand_a = (exec && reads_reg_a(op)) ? pick_index() : pick_immediate();
    b.operand_b = (exec && reads_reg_b(op)) ? pick_index() : pick_immediate();
    b.operand_c = pick_index();
    return b;
  endfunction

  task automatic send_beat(fralu_pkg::in_t beat, bit fixed, fralu_pkg::out_t result);
    while ($urandom_range(0, 99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_data     <= beat;
    beat_fixed  <= fixed;
    beat_result <= result;
    beats_sent++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Hold the input idle until every beat sent has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (results_checked < beats_sent) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
  endtask

  task automatic write_cfg(logic [fralu_pkg::CFG_INDEX_W-1:0] index,
                           logic [fralu_pkg::CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    if (index == fralu_pkg::CFG_OPCODE_MAP) arch_map = value;
    else arch_use_map = value[0];
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predicted = alu_step(in_data);
        pending_results.push_back(beat_fixed ? beat_result : predicted);
      end
      if (out_valid && out_ready) begin
        results_checked++;
        if (pending_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: result beat with nothing expected: expected none got %h",
                   $time, out_data);
        end else begin
          oldest = pending_results.pop_front();
          compare_field("reg0", oldest.reg0, out_data.reg0);
          compare_field("reg1", oldest.reg1, out_data.reg1);
          compare_field("reg2", oldest.reg2, out_data.reg2);
          compare_field("reg3", oldest.reg3, out_data.reg3);
          compare_field("fault", 32'(oldest.fault), 32'(out_data.fault));
        end
      end
    end
  end

  initial begin
    directed_t                        directed [$];
    logic [fralu_pkg::CFG_DATA_W-1:0] map_value;
    logic                             use_value;

    arch_regs    = '{default: '0};
    arch_map     = fralu_pkg::OPCODE_MAP_RESET;
    arch_use_map = 1'b1;

    // Reset map is the identity, so opcodes below name operations directly
    directed.push_back(directed_row(fralu_pkg::CMD_EXEC, fralu_pkg::OP_ADDR, 0, 0, 0, 1'b1,
                                    0, 0, 0, 0, 1'b0));
    directed.push_back(directed_row(fralu_pkg::CMD_LOAD, fralu_pkg::OP_MULR,
                                    32'h7FFF_FFFF, 32'h8000_0000, 0, 1'b1,
                                    32'h7FFF_FFFF, 0, 0, 0, 1'b0));
    directed.push_back(directed_row(fralu_pkg::CMD_LOAD, fralu_pkg::OP_EQRR,
                                    32'h8000_0000, -1, 1, 1'b1,
                                    32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 1'b0));
    directed.push_back(directed_row(fralu_pkg::CMD_LOAD, fralu_pkg::OP_SETI, -1, 7, 2, 1'b1,
                                    32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0, 1'b0));
    directed.push_back(directed_row(fralu_pkg::CMD_LOAD, fralu_pkg::OP_ADDR, 1, 0, 3, 1'b1,
                                    32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1, 1'b0));
    // Out-of-range destination, source A and source B: nothing written
    directed.push_back(directed_row(fralu_pkg::CMD_LOAD, fralu_pkg::OP_ADDR, 5, 0, 4, 1'b1,
                                    32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1, 1'b1));
    directed.push_back(directed_row(fralu_pkg::CMD_LOAD, fralu_pkg::OP_ADDR, 5, 0, -1, 1'b1,
                                    32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1, 1'b1));
    directed.push_back(directed_row(fralu_pkg::CMD_EXEC, fralu_pkg::OP_ADDR, 4, 0, 0, 1'b1,
                                    32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1, 1'b1));
    directed.push_back(directed_row(fralu_pkg::CMD_EXEC, fralu_pkg::OP_ADDR, 0, -1, 0, 1'b1,
                                    32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1, 1'b1));
    directed.push_back(directed_row(fralu_pkg::CMD_EXEC, fralu_pkg::OP_ADDR,
                                    0, 0, 32'h8000_0000, 1'b1,
                                    32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1, 1'b1));
    directed.push_back(directed_row(fralu_pkg::CMD_EXEC, fralu_pkg::OP_ADDR, 0, 3, 3));
    directed.push_back(directed_row(fralu_pkg::CMD_EXEC, fralu_pkg::OP_ADDI, 2, -1, 2));
    directed.push_back(directed_row(fralu_pkg::CMD_EXEC, fralu_pkg::OP_MULR, 2, 0, 2));
    directed.push_back(directed_row(fralu_pkg::CMD_EXEC, fralu_pkg::OP_MULI,
                                    1, 32'h7FFF_FFFF, 1));
    directed.push_back(directed_row(fralu_pkg::CMD_EXEC, fralu_pkg::OP_BANR, 0, 2, 3));
    directed.push_back(directed_row(fralu_pkg::CMD_EXEC, fralu_pkg::OP_BANI,
                                    0, 32'h8000_0000, 2));
    directed.push_back(directed_row(fralu_pkg::CMD_EXEC, fralu_pkg::OP_BORR, 1, 2, 1));
    directed.push_back(directed_row(fralu_pkg::CMD_EXEC, fralu_pkg::OP_BORI,
                                    3, 32'h0000_FFFF, 3));
    // B is ignored by setr and seti, A is an immediate for seti and B for gtri
    directed.push_back(directed_row(fralu_pkg::CMD_EXEC, fralu_pkg::OP_SETR, 1, -7, 0));
    directed.push_back(directed_row(fralu_pkg::CMD_EXEC, fralu_pkg::OP_SETI,
                                    32'h8000_0000, 32'h7FFF_FFFF, 2));
    directed.push_back(directed_row(fralu_pkg::CMD_EXEC, fralu_pkg::OP_GTIR, -1, 3, 1));
    directed.push_back(directed_row(fralu_pkg::CMD_EXEC, fralu_pkg::OP_GTRI,
                                    0, 32'h8000_0000, 3));
    directed.push_back(directed_row(fralu_pkg::CMD_EXEC, fralu_pkg::OP_GTRR, 2, 0, 0));
    directed.push_back(directed_row(fralu_pkg::CMD_EXEC, fralu_pkg::OP_EQIR, 0, 0, 2));
    directed.push_back(directed_row(fralu_pkg::CMD_EXEC, fralu_pkg::OP_EQRI, 2, 1, 1));
    directed.push_back(directed_row(fralu_pkg::CMD_EXEC, fralu_pkg::OP_EQRR, 3, 3, 0));
    directed.push_back(directed_row(fralu_pkg::CMD_EXEC, fralu_pkg::OP_GTIR, 5, 4, 0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_beat(directed[i].beat, directed[i].fixed, directed[i].result);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      case (phase)
        0:       begin map_value = '0;               use_value = 1'b0; end
        1:       begin map_value = '1;               use_value = 1'b1; end
        3:       begin map_value = {$urandom, $urandom}; use_value = 1'b0; end
        5:       begin map_value = fralu_pkg::OPCODE_MAP_RESET; use_value = 1'b1; end
        6:       begin map_value = '0;               use_value = 1'b1; end
        default: begin map_value = {$urandom, $urandom}; use_value = 1'b1; end
      endcase
      write_cfg(fralu_pkg::CFG_OPCODE_MAP, map_value);
      write_cfg(fralu_pkg::CFG_USE_MAP, fralu_pkg::CFG_DATA_W'(use_value));
      cfg_we <= 1'b0;
      case (phase % 4)
        0:       begin sender_gap_pct = 0;  receiver_stall_pct = 0;  end
        1:       begin sender_gap_pct = 79; receiver_stall_pct = 0;  end
        2:       begin sender_gap_pct = 0;  receiver_stall_pct = 79; end
        default: begin sender_gap_pct = 13; receiver_stall_pct = 13; end
      endcase
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // Let the pipeline run dry once in the middle of a phase
        if (phase == 2 && n == PHASE_BEATS / 2) drain_results();
        send_beat(random_instruction(), 1'b0, '0);
      end
    end

    drain_results();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
